// ----- rtl/union_find_engine_assert.svh -----
`ifndef UNION_FIND_ENGINE_ASSERT_SVH
`define UNION_FIND_ENGINE_ASSERT_SVH

// same-cycle implication
`define UFE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define UFE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/uf_pkg.sv -----
package uf_pkg;

   localparam int MAX_ELEMENTS = 1024;
   localparam int ELEM_W       = $clog2(MAX_ELEMENTS);
   localparam int COUNT_W      = ELEM_W + 1;

   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_IDX_W    = CSR_ADDR_W - 2;

   localparam logic [CSR_IDX_W-1:0] REG_ELEMENT_COUNT = '0;

   localparam logic MODE_FIND = 1'b0;
   localparam logic MODE_JOIN = 1'b1;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_FIND_RD,
      S_FIND_CHK,
      S_COMP_CHK,
      S_PHASE_END,
      S_SIZE_RD,
      S_SIZE_A,
      S_SIZE_B,
      S_DONE
   } state_type;

   typedef struct packed {
      logic accept;
      logic find_step;
      logic comp_step;
      logic save_ra;
      logic start_b;
      logic save_rb;
      logic size_rd_b;
      logic res_lone;
      logic res_find;
      logic link;
      logic clear_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic req_a_ok;
      logic req_b_ok;
      logic req_is_join;
      logic a_ok;
      logic b_ok;
      logic is_join;
      logic p_is_self;
      logic x_is_root;
      logic p_is_root;
      logic roots_differ;
      logic clear_last;
      logic cfg_write;
      logic out_free;
   } status_type;

endpackage

// ----- rtl/uf_ram.sv -----
module uf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/uf_dpath.sv -----
module uf_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  uf_pkg::cmd_type               cmd,
   output uf_pkg::status_type            status,
   input  logic                          req_mode,
   input  logic [uf_pkg::ELEM_W-1:0]     req_first_element,
   input  logic [uf_pkg::ELEM_W-1:0]     req_second_element,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [uf_pkg::ELEM_W-1:0]     rsp_set_root,
   output logic [uf_pkg::COUNT_W-1:0]    rsp_set_size,
   output logic                          rsp_merged,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [uf_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [uf_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [uf_pkg::CSR_DATA_W-1:0] prdata,
   output logic                          pready
);
   import uf_pkg::*;

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [ELEM_W-1:0]  clr_idx_ff, clr_idx_in;

   logic               mode_ff, mode_in;
   logic               a_ok_ff, a_ok_in;
   logic               b_ok_ff, b_ok_in;
   logic [ELEM_W-1:0]  a_ff, a_in;
   logic [ELEM_W-1:0]  b_ff, b_in;
   logic [ELEM_W-1:0]  cur_ff, cur_in;
   logic [ELEM_W-1:0]  x_ff, x_in;
   logic [ELEM_W-1:0]  walk_ff, walk_in;
   logic [ELEM_W-1:0]  root_ff, root_in;
   logic [ELEM_W-1:0]  ra_ff, ra_in;
   logic [ELEM_W-1:0]  rb_ff, rb_in;
   logic [COUNT_W-1:0] size_a_ff, size_a_in;

   logic [ELEM_W-1:0]  res_root_ff, res_root_in;
   logic [COUNT_W-1:0] res_size_ff, res_size_in;
   logic               res_merged_ff, res_merged_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [ELEM_W-1:0]  rsp_root_ff, rsp_root_in;
   logic [COUNT_W-1:0] rsp_size_ff, rsp_size_in;
   logic               rsp_merged_ff, rsp_merged_in;

   logic [ELEM_W-1:0]  par_q;
   logic [COUNT_W-1:0] size_q;
   logic [ELEM_W-1:0]  par_rd_addr, par_wr_addr, par_wr_data;
   logic               par_wr_en;
   logic [ELEM_W-1:0]  size_rd_addr, size_wr_addr;
   logic [COUNT_W-1:0] size_wr_data;
   logic               size_wr_en;

   logic               csr_hit;
   logic [COUNT_W-1:0] wr_value;
   logic               a_wins;
   logic [ELEM_W-1:0]  winner, loser;
   logic [COUNT_W-1:0] sum;

   // configuration
   assign pready   = 1'b1;
   assign csr_hit  = psel && penable && pwrite && pready &&
                     (paddr[CSR_ADDR_W-1:2] == REG_ELEMENT_COUNT);
   assign wr_value = pwdata[COUNT_W-1:0];
   assign prdata   = (paddr[CSR_ADDR_W-1:2] == REG_ELEMENT_COUNT) ?
                     CSR_DATA_W'(count_ff) : '0;

   always_comb begin
      count_in = count_ff;
      if (csr_hit) begin
         if (wr_value == '0) begin
            count_in = COUNT_W'(1);
         end else if (wr_value > COUNT_W'(MAX_ELEMENTS)) begin
            count_in = COUNT_W'(MAX_ELEMENTS);
         end else begin
            count_in = wr_value;
         end
      end
   end

   always_comb begin
      clr_idx_in = clr_idx_ff;
      if (csr_hit) begin
         clr_idx_in = '0;
      end else if (cmd.clear_step) begin
         clr_idx_in = clr_idx_ff + 1'b1;
      end
   end

   // link decision
   assign a_wins = !(size_a_ff < size_q);
   assign winner = a_wins ? ra_ff : rb_ff;
   assign loser  = a_wins ? rb_ff : ra_ff;
   assign sum    = size_a_ff + size_q;

   // item registers
   always_comb begin
      mode_in       = mode_ff;
      a_ok_in       = a_ok_ff;
      b_ok_in       = b_ok_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      cur_in        = cur_ff;
      x_in          = x_ff;
      walk_in       = walk_ff;
      root_in       = root_ff;
      ra_in         = ra_ff;
      rb_in         = rb_ff;
      size_a_in     = size_a_ff;
      res_root_in   = res_root_ff;
      res_size_in   = res_size_ff;
      res_merged_in = res_merged_ff;
      if (cmd.accept) begin
         mode_in = req_mode;
         a_in    = req_first_element;
         b_in    = req_second_element;
         a_ok_in = status.req_a_ok;
         b_ok_in = status.req_b_ok;
         cur_in  = status.req_a_ok ? req_first_element : req_second_element;
         x_in    = status.req_a_ok ? req_first_element : req_second_element;
      end
      if (cmd.find_step) begin
         if (status.p_is_self) begin
            root_in = cur_ff;
            walk_in = x_ff;
         end else begin
            cur_in = par_q;
         end
      end
      if (cmd.comp_step) begin
         walk_in = par_q;
      end
      if (cmd.save_ra) begin
         ra_in = root_ff;
      end
      if (cmd.start_b) begin
         cur_in = b_ff;
         x_in   = b_ff;
      end
      if (cmd.save_rb) begin
         rb_in = root_ff;
      end
      if (cmd.size_rd_b) begin
         size_a_in = size_q;
      end
      if (cmd.res_lone) begin
         res_root_in   = a_ff;
         res_size_in   = COUNT_W'(1);
         res_merged_in = 1'b0;
      end
      if (cmd.res_find) begin
         res_root_in   = ra_ff;
         res_size_in   = size_q;
         res_merged_in = 1'b0;
      end
      if (cmd.link) begin
         res_root_in   = winner;
         res_size_in   = sum;
         res_merged_in = 1'b1;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_root_in   = rsp_root_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_merged_in = rsp_merged_ff;
      if (cmd.out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_root_in   = res_root_ff;
         rsp_size_in   = res_size_ff;
         rsp_merged_in = res_merged_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= COUNT_W'(MAX_ELEMENTS);
         clr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         clr_idx_ff   <= clr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      a_ok_ff       <= a_ok_in;
      b_ok_ff       <= b_ok_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      cur_ff        <= cur_in;
      x_ff          <= x_in;
      walk_ff       <= walk_in;
      root_ff       <= root_in;
      ra_ff         <= ra_in;
      rb_ff         <= rb_in;
      size_a_ff     <= size_a_in;
      res_root_ff   <= res_root_in;
      res_size_ff   <= res_size_in;
      res_merged_ff <= res_merged_in;
      rsp_root_ff   <= rsp_root_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_merged_ff <= rsp_merged_in;
   end

   // memory ports
   always_comb begin
      par_rd_addr = cur_ff;
      if (cmd.find_step) begin
         par_rd_addr = status.p_is_self ? x_ff : par_q;
      end else if (cmd.comp_step) begin
         par_rd_addr = par_q;
      end
   end

   always_comb begin
      par_wr_en    = 1'b0;
      par_wr_addr  = clr_idx_ff;
      par_wr_data  = clr_idx_ff;
      size_wr_en   = 1'b0;
      size_wr_addr = clr_idx_ff;
      size_wr_data = COUNT_W'(1);
      if (cmd.clear_step) begin
         par_wr_en  = 1'b1;
         size_wr_en = 1'b1;
      end else if (cmd.comp_step) begin
         par_wr_en   = 1'b1;
         par_wr_addr = walk_ff;
         par_wr_data = root_ff;
      end else if (cmd.link) begin
         par_wr_en    = 1'b1;
         par_wr_addr  = loser;
         par_wr_data  = winner;
         size_wr_en   = 1'b1;
         size_wr_addr = winner;
         size_wr_data = sum;
      end
   end

   assign size_rd_addr = cmd.size_rd_b ? rb_ff : ra_ff;

   uf_ram #(
      .WIDTH (ELEM_W),
      .DEPTH (MAX_ELEMENTS)
   ) u_parent_ram (
      .clock   (clock),
      .wr_en   (par_wr_en),
      .wr_addr (par_wr_addr),
      .wr_data (par_wr_data),
      .rd_addr (par_rd_addr),
      .rd_data (par_q)
   );

   uf_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (MAX_ELEMENTS)
   ) u_size_ram (
      .clock   (clock),
      .wr_en   (size_wr_en),
      .wr_addr (size_wr_addr),
      .wr_data (size_wr_data),
      .rd_addr (size_rd_addr),
      .rd_data (size_q)
   );

   // status
   always_comb begin
      status              = '0;
      status.req_a_ok     = {1'b0, req_first_element} < count_ff;
      status.req_b_ok     = {1'b0, req_second_element} < count_ff;
      status.req_is_join  = (req_mode == MODE_JOIN);
      status.a_ok         = a_ok_ff;
      status.b_ok         = b_ok_ff;
      status.is_join      = (mode_ff == MODE_JOIN);
      status.p_is_self    = (par_q == cur_ff);
      status.x_is_root    = (x_ff == cur_ff);
      status.p_is_root    = (par_q == root_ff);
      status.roots_differ = (ra_ff != rb_ff);
      status.clear_last   = ({1'b0, clr_idx_ff} == (count_ff - 1'b1));
      status.cfg_write    = csr_hit;
      status.out_free     = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_set_root = rsp_root_ff;
   assign rsp_set_size = rsp_size_ff;
   assign rsp_merged   = rsp_merged_ff;

endmodule

// ----- rtl/uf_ctrl.sv -----
`include "union_find_engine_assert.svh"

module uf_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  uf_pkg::status_type status,
   output uf_pkg::cmd_type    cmd
);
   import uf_pkg::*;

   state_type state_ff, state_in;
   logic      phase_b_ff, phase_b_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         phase_b_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         phase_b_ff <= phase_b_in;
      end
   end

   // next state
   always_comb begin
      state_in   = state_ff;
      phase_b_in = phase_b_ff;
      if (status.cfg_write) begin
         state_in = S_CLEAR;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               if (status.clear_last) begin
                  state_in = S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  if (status.req_a_ok) begin
                     state_in   = S_FIND_RD;
                     phase_b_in = 1'b0;
                  end else if (status.req_is_join && status.req_b_ok) begin
                     state_in   = S_FIND_RD;
                     phase_b_in = 1'b1;
                  end else begin
                     state_in   = S_PHASE_END;
                     phase_b_in = 1'b1;
                  end
               end
            end
            S_FIND_RD: state_in = S_FIND_CHK;
            S_FIND_CHK: begin
               if (status.p_is_self) begin
                  state_in = status.x_is_root ? S_PHASE_END : S_COMP_CHK;
               end
            end
            S_COMP_CHK: begin
               if (status.p_is_root) begin
                  state_in = S_PHASE_END;
               end
            end
            S_PHASE_END: begin
               if (phase_b_ff) begin
                  state_in = status.a_ok ? S_SIZE_RD : S_DONE;
               end else if (status.is_join && status.b_ok) begin
                  state_in   = S_FIND_RD;
                  phase_b_in = 1'b1;
               end else begin
                  state_in = S_SIZE_RD;
               end
            end
            S_SIZE_RD: state_in = S_SIZE_A;
            S_SIZE_A: begin
               if (status.is_join && status.b_ok && status.roots_differ) begin
                  state_in = S_SIZE_B;
               end else begin
                  state_in = S_DONE;
               end
            end
            S_SIZE_B: state_in = S_DONE;
            S_DONE: begin
               if (status.out_free) begin
                  state_in = S_IDLE;
               end
            end
            default: state_in = S_CLEAR;
         endcase
      end
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_CLEAR: cmd.clear_step = 1'b1;
         S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         S_FIND_RD: ;
         S_FIND_CHK: cmd.find_step = 1'b1;
         S_COMP_CHK: cmd.comp_step = 1'b1;
         S_PHASE_END: begin
            if (phase_b_ff) begin
               if (status.a_ok) begin
                  cmd.save_rb = 1'b1;
               end else begin
                  cmd.res_lone = 1'b1;
               end
            end else begin
               cmd.save_ra = 1'b1;
               cmd.start_b = status.is_join && status.b_ok;
            end
         end
         S_SIZE_RD: ;
         S_SIZE_A: begin
            if (status.is_join && status.b_ok && status.roots_differ) begin
               cmd.size_rd_b = 1'b1;
            end else begin
               cmd.res_find = 1'b1;
            end
         end
         S_SIZE_B: cmd.link = 1'b1;
         S_DONE: cmd.out_load = status.out_free;
         default: ;
      endcase
   end

   `UFE_ASSERT_NEXT(ap_accept_starts, clock, reset, cmd.accept && !status.cfg_write, state_ff == S_FIND_RD || state_ff == S_PHASE_END, "item accepted but walk not started")
   `UFE_ASSERT_NOW(ap_phase_b_entry, clock, reset, $rose(phase_b_ff), $past(state_ff) == S_IDLE || $past(state_ff) == S_PHASE_END, "second walk entered from wrong state")
   `UFE_ASSERT_NOW(ap_link_legal, clock, reset, cmd.link, phase_b_ff && status.a_ok && status.b_ok && status.is_join, "link without two in-range join operands")
   `UFE_ASSERT_NEXT(ap_clear_done, clock, reset, state_ff == S_CLEAR && status.clear_last && !status.cfg_write, state_ff == S_IDLE, "clear sweep did not end")

endmodule

// ----- rtl/union_find_engine.sv -----
// Disjoint-set table, union by size with path compression.
// req_ channel: one item is mode (find or join), first_element and
// second_element; taken when req_valid and req_ready are high together.
// rsp_ channel: one item per request with set_root, set_size and merged,
// held in an output register until rsp_ready takes it. The next request
// is accepted while that result still waits; a result that cannot leave
// holds the block in its final state.
// One item at a time, set by the single read port of the parent memory.
// A find reads one parent per hop while walking from the element up to
// its root, then writes one parent per hop while compressing the path. A
// join runs two such walks, then the size reads and the link. An element
// at or above element_count is not walked, but a join still walks an
// in-range second element. The next item can be taken at the earliest in
// the cycle in which rsp_valid rises.
// Reset (synchronous) starts a clearing sweep of all 1024 entries; a write
// of element_count starts a sweep of the first element_count entries. No
// request is taken during a sweep. element_count lives at byte address 0.
module union_find_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_mode,
   input  logic [uf_pkg::ELEM_W-1:0]     req_first_element,
   input  logic [uf_pkg::ELEM_W-1:0]     req_second_element,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [uf_pkg::ELEM_W-1:0]     rsp_set_root,
   output logic [uf_pkg::COUNT_W-1:0]    rsp_set_size,
   output logic                          rsp_merged,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [uf_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [uf_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [uf_pkg::CSR_DATA_W-1:0] prdata,
   output logic                          pready
);
   import uf_pkg::*;

   cmd_type    cmd;
   status_type status;

   uf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   uf_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_mode           (req_mode),
      .req_first_element  (req_first_element),
      .req_second_element (req_second_element),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_set_root       (rsp_set_root),
      .rsp_set_size       (rsp_set_size),
      .rsp_merged         (rsp_merged),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

endmodule

// ----- sim/tb_union_find_engine.sv -----
module tb_union_find_engine;
   import uf_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [ELEM_W-1:0]  root;
      logic [COUNT_W-1:0] size;
      logic               merged;
   } set_result_type;

   // Union by size with full path compression, tracked alongside the block
   class set_tracker;
      int unsigned parent[MAX_ELEMENTS];
      int unsigned members[MAX_ELEMENTS];
      int unsigned live_count;
      set_result_type expected[$];
      int mismatches;

      function void resize(int unsigned value);
         int unsigned v;
         v = value & ((1 << COUNT_W) - 1);
         if (v < 1) v = 1;
         if (v > MAX_ELEMENTS) v = MAX_ELEMENTS;
         live_count = v;
         for (int i = 0; i < MAX_ELEMENTS; i++) begin
            parent[i] = i;
            members[i] = 1;
         end
      endfunction

      function int unsigned find_root(int unsigned x);
         int unsigned r;
         int unsigned hops;
         int unsigned above;
         r = x;
         hops = 0;
         while (parent[r] != r && hops < live_count) begin
            above = parent[r];
            if (above >= live_count) break;
            r = above;
            hops++;
         end
         hops = 0;
         while (x != r && hops < live_count) begin
            above = parent[x];
            parent[x] = r;
            if (above >= live_count) break;
            x = above;
            hops++;
         end
         return r;
      endfunction

      function void note_request(logic mode, logic [ELEM_W-1:0] a, logic [ELEM_W-1:0] b);
         int unsigned ra;
         int unsigned rb;
         int unsigned root;
         int unsigned size;
         logic merged;
         set_result_type res;
         root = a;
         size = 1;
         merged = 1'b0;
         if (a < live_count) begin
            ra = find_root(a);
            root = ra;
            if (mode == MODE_JOIN && b < live_count) begin
               rb = find_root(b);
               if (ra != rb) begin
                  if (members[ra] < members[rb]) begin
                     parent[ra] = rb;
                     members[rb] += members[ra];
                     root = rb;
                  end else begin
                     parent[rb] = ra;
                     members[ra] += members[rb];
                     root = ra;
                  end
                  merged = 1'b1;
               end
            end
            size = members[root];
         end else if (mode == MODE_JOIN && b < live_count) begin
            void'(find_root(b));
         end
         res.root = root[ELEM_W-1:0];
         res.size = size[COUNT_W-1:0];
         res.merged = merged;
         expected = {expected, res};
      endfunction

      function void check_result(logic [ELEM_W-1:0] root, logic [COUNT_W-1:0] size,
                                 logic merged);
         set_result_type want;
         if (expected.size() == 0) begin
            $error("result with none pending: set_root=%0d set_size=%0d merged=%0d",
                   root, size, merged);
            mismatches++;
            return;
         end
         want = expected.pop_front();
         if (root !== want.root) begin
            $error("set_root: expected %0d, got %0d", want.root, root);
            mismatches++;
         end
         if (size !== want.size) begin
            $error("set_size: expected %0d, got %0d", want.size, size);
            mismatches++;
         end
         if (merged !== want.merged) begin
            $error("merged: expected %0d, got %0d", want.merged, merged);
            mismatches++;
         end
      endfunction

      function int outstanding();
         return expected.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_mode = MODE_FIND;
   logic [ELEM_W-1:0]     req_first_element = '0;
   logic [ELEM_W-1:0]     req_second_element = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [ELEM_W-1:0]     rsp_set_root;
   logic [COUNT_W-1:0]    rsp_set_size;
   logic                  rsp_merged;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   bit steady = 1'b0;
   int stall_left = 0;
   int idle_cycles = 0;
   set_tracker tracker = new();

   union_find_engine uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_first_element  (req_first_element),
      .req_second_element (req_second_element),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_set_root       (rsp_set_root),
      .rsp_set_size       (rsp_set_size),
      .rsp_merged         (rsp_merged),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   always #5 clock = ~clock;

   function automatic int pick_gap();
      int roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [ELEM_W-1:0] pick_element(int unsigned limit);
      if ($urandom_range(0, 99) < 88) return ELEM_W'($urandom_range(0, limit - 1));
      return ELEM_W'($urandom_range(0, MAX_ELEMENTS - 1));
   endfunction

   function automatic logic pick_mode();
      return ($urandom_range(0, 99) < 60) ? MODE_JOIN : MODE_FIND;
   endfunction

   // result side back-pressure
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (!steady && $urandom_range(0, 99) < 25) stall_left <= pick_gap();
      end
   end

   // monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            tracker.check_result(rsp_set_root, rsp_set_size, rsp_merged);
         if (req_valid && req_ready)
            tracker.note_request(req_mode, req_first_element, req_second_element);
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (psel && penable && pwrite && pready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic send_item(input logic mode, input logic [ELEM_W-1:0] a,
                            input logic [ELEM_W-1:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_first_element <= a;
      req_second_element <= b;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.outstanding() != 0) @(posedge clock);
   endtask

   task automatic write_element_count(input int unsigned value);
      drain();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {REG_ELEMENT_COUNT, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      tracker.resize(value);
   endtask

   task automatic random_phase(input int unsigned count, input int items);
      write_element_count(count);
      repeat (items)
         send_item(pick_mode(), pick_element(count), pick_element(count));
   endtask

   initial begin
      tracker.resize(MAX_ELEMENTS);
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // full table after reset
      send_item(MODE_FIND, 10'd0, 10'd1023);
      send_item(MODE_FIND, 10'd1023, 10'd0);
      send_item(MODE_JOIN, 10'd0, 10'd1);
      send_item(MODE_JOIN, 10'd1, 10'd0);
      send_item(MODE_JOIN, 10'd2, 10'd0);
      send_item(MODE_JOIN, 10'd1023, 10'd512);
      send_item(MODE_JOIN, 10'd1023, 10'd0);
      send_item(MODE_FIND, 10'd1023, 10'd1023);
      send_item(MODE_JOIN, 10'd5, 10'd5);
      send_item(MODE_JOIN, 10'd682, 10'd341);

      // elements beyond the count
      write_element_count(4);
      send_item(MODE_FIND, 10'd4, 10'd0);
      send_item(MODE_FIND, 10'd1023, 10'd1);
      send_item(MODE_JOIN, 10'd0, 10'd9);
      send_item(MODE_JOIN, 10'd9, 10'd1);
      send_item(MODE_JOIN, 10'd0, 10'd1);
      send_item(MODE_JOIN, 10'd2, 10'd3);
      send_item(MODE_JOIN, 10'd0, 10'd2);
      send_item(MODE_FIND, 10'd3, 10'd2);
      send_item(MODE_JOIN, 10'd1023, 10'd1023);

      // zero count clamps to one
      write_element_count(0);
      send_item(MODE_JOIN, 10'd0, 10'd0);
      send_item(MODE_JOIN, 10'd0, 10'd1);

      // oversized count clamps to the table size
      write_element_count((1 << COUNT_W) - 1);
      send_item(MODE_JOIN, 10'd1023, 10'd0);
      send_item(MODE_FIND, 10'd0, 10'd0);

      write_element_count(2);
      send_item(MODE_JOIN, 10'd1, 10'd0);
      send_item(MODE_FIND, 10'd0, 10'd1);

      random_phase(16, 100);
      steady = 1'b1;
      random_phase(64, 60);
      steady = 1'b0;
      random_phase(MAX_ELEMENTS, 80);
      random_phase(5, 60);
      random_phase(1, 20);
      random_phase(300, 80);

      drain();
      repeat (40) @(posedge clock);
      if (tracker.mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- union_find_engine.f -----
+incdir+rtl
rtl/uf_pkg.sv
rtl/uf_ram.sv
rtl/uf_dpath.sv
rtl/uf_ctrl.sv
rtl/union_find_engine.sv
sim/tb_union_find_engine.sv
